/* sv/sbc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbc_pkg
// Shared constants and controller/datapath interface types for the sector
// buffer cache replacement core.
// ----------------------------------------------------------------------------
package sbc_pkg;

   localparam int SLOTS  = 16;
   localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int VOL_W  = 4;
   localparam int SEC_W  = 32;
   localparam int TICK_W = 32;
   localparam int SLOT_W = 4;

   // request beat layout
   localparam int REQ_DATA_W = VOL_W + SEC_W + TICK_W + SLOT_W;
   localparam int RSP_DATA_W = 8;

   typedef enum logic {
      OP_LOOKUP = 1'b0,
      OP_INVAL  = 1'b1
   } op_type;

   typedef struct packed {
      logic load;     // capture request, restart scan
      logic scan;     // evaluate the slot under the scan index
      logic commit;   // update the store and load the response register
   } cmd_type;

   typedef struct packed {
      logic is_inval; // captured request is an invalidate
      logic match;    // slot under the scan index holds the requested tag
      logic last;     // scan index is on the final slot
      logic rsp_hold; // response register still holds an untaken beat
   } sts_type;

endpackage

/* sv/sbc_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbc_ctrl
// Sequencer: accepts one request, steps the tag scan for a lookup, then commits.
// ----------------------------------------------------------------------------
module sbc_ctrl
   import sbc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_UPDATE = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // an invalidate needs no scan
            if (sts.is_inval) begin
               state_in = ST_UPDATE;
            end else begin
               cmd.scan = 1'b1;
               if (sts.match || sts.last) begin
                  state_in = ST_UPDATE;
               end
            end
         end
         ST_UPDATE: begin
            // hold until the response register is free
            if (!sts.rsp_hold) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* sv/sbc_dpath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbc_dpath
// Tag, age and valid store with a one-slot-per-cycle scan for hit and
// least recently used victim, plus the response register.
// ----------------------------------------------------------------------------
module sbc_dpath
   import sbc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output sts_type           sts,
   input  logic              req_opcode,
   input  logic [VOL_W-1:0]  req_volume_id,
   input  logic [SEC_W-1:0]  req_sector,
   input  logic [TICK_W-1:0] req_tick,
   input  logic [SLOT_W-1:0] req_target_slot,
   input  logic              rsp_tready,
   output logic              rsp_tvalid,
   output logic              rsp_hit,
   output logic [SLOT_W-1:0] rsp_slot,
   output logic              rsp_victim_was_valid
);

   logic              valid_ff [SLOTS];
   logic [VOL_W-1:0]  vol_ff   [SLOTS];
   logic [SEC_W-1:0]  sec_ff   [SLOTS];
   logic [TICK_W-1:0] age_ff   [SLOTS];

   op_type            rq_op_ff;
   logic [VOL_W-1:0]  rq_vol_ff;
   logic [SEC_W-1:0]  rq_sec_ff;
   logic [TICK_W-1:0] rq_tick_ff;
   logic [SLOT_W-1:0] rq_tgt_ff;

   logic [IDX_W-1:0]  idx_ff;
   logic [IDX_W-1:0]  pick_ff;
   logic [TICK_W-1:0] min_ff;
   logic              hit_ff;

   logic              rsp_valid_ff;
   logic              rsp_hit_ff;
   logic [SLOT_W-1:0] rsp_slot_ff;
   logic              rsp_vv_ff;

   logic              match;
   logic              last;
   logic              tgt_in_range;
   logic [IDX_W-1:0]  tgt_idx;

   assign match = valid_ff[idx_ff] && (vol_ff[idx_ff] == rq_vol_ff)
                  && (sec_ff[idx_ff] == rq_sec_ff);
   assign last  = (idx_ff == IDX_W'(SLOTS - 1));

   assign tgt_in_range = ({{(32 - SLOT_W){1'b0}}, rq_tgt_ff} < 32'(SLOTS));
   assign tgt_idx      = IDX_W'(rq_tgt_ff);

   assign sts.is_inval = (rq_op_ff == OP_INVAL);
   assign sts.match    = match;
   assign sts.last     = last;
   assign sts.rsp_hold = rsp_valid_ff && !rsp_tready;

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rq_op_ff   <= op_type'(req_opcode);
         rq_vol_ff  <= req_volume_id;
         rq_sec_ff  <= req_sector;
         rq_tick_ff <= req_tick;
         rq_tgt_ff  <= req_target_slot;
      end
   end

   // scan: first match wins; oldest age wins, later slot on a tie
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         idx_ff <= '0;
         hit_ff <= 1'b0;
      end else if (cmd.scan) begin
         if (match) begin
            hit_ff  <= 1'b1;
            pick_ff <= idx_ff;
         end else begin
            if ((idx_ff == '0) || (age_ff[idx_ff] <= min_ff)) begin
               pick_ff <= idx_ff;
               min_ff  <= age_ff[idx_ff];
            end
            if (!last) begin
               idx_ff <= idx_ff + 1'b1;
            end
         end
      end
   end

   // store update
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            valid_ff[i] <= 1'b0;
            age_ff[i]   <= '0;
         end
      end else if (cmd.commit) begin
         if (rq_op_ff == OP_INVAL) begin
            if (tgt_in_range) begin
               valid_ff[tgt_idx] <= 1'b0;
            end
         end else if (hit_ff) begin
            age_ff[pick_ff] <= rq_tick_ff;
         end else begin
            valid_ff[pick_ff] <= 1'b1;
            vol_ff[pick_ff]   <= rq_vol_ff;
            sec_ff[pick_ff]   <= rq_sec_ff;
            age_ff[pick_ff]   <= rq_tick_ff;
         end
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         if (rq_op_ff == OP_INVAL) begin
            rsp_hit_ff  <= 1'b0;
            rsp_slot_ff <= rq_tgt_ff;
            rsp_vv_ff   <= 1'b0;
         end else begin
            rsp_hit_ff  <= hit_ff;
            rsp_slot_ff <= SLOT_W'(pick_ff);
            rsp_vv_ff   <= !hit_ff && valid_ff[pick_ff];
         end
      end
   end

   assign rsp_tvalid           = rsp_valid_ff;
   assign rsp_hit              = rsp_hit_ff;
   assign rsp_slot             = rsp_slot_ff;
   assign rsp_victim_was_valid = rsp_vv_ff;

endmodule

/* sv/sector_buffer_cache_replacement_core.sv */
`timescale 1ns / 1ps
// Sequence: an invalidate passes from accept through the scan state straight
// to its update; a lookup scans until a hit, or all SLOTS slots on a miss.
// Throughput: one request at a time, set by the tag scan that examines one
// slot per cycle; a stalled response holds the next request in its update
// step.
// Reset: synchronous; clears all valid marks and ages, empties the response.
// ----------------------------------------------------------------------------
// sector_buffer_cache_replacement_core
// Tag and LRU replacement store for a sector buffer cache: lookups report
// hit slot or refill victim, invalidates clear one slot.
// ----------------------------------------------------------------------------
module sector_buffer_cache_replacement_core
   import sbc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [3:0] volume_id, [35:4] sector, [67:36] tick, [71:68] target_slot
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [0] opcode
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [3:0] slot, [4] victim_was_valid, [7:5] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // [0] hit
   output logic                  rsp_tuser
);

   cmd_type           cmd;
   sts_type           sts;
   logic [SLOT_W-1:0] rsp_slot;
   logic              rsp_vv;

   sbc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   sbc_dpath u_dpath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .sts                  (sts),
      .req_opcode           (req_tuser),
      .req_volume_id        (req_tdata[VOL_W-1:0]),
      .req_sector           (req_tdata[VOL_W+SEC_W-1:VOL_W]),
      .req_tick             (req_tdata[VOL_W+SEC_W+TICK_W-1:VOL_W+SEC_W]),
      .req_target_slot      (req_tdata[REQ_DATA_W-1:VOL_W+SEC_W+TICK_W]),
      .rsp_tready           (rsp_tready),
      .rsp_tvalid           (rsp_tvalid),
      .rsp_hit              (rsp_tuser),
      .rsp_slot             (rsp_slot),
      .rsp_victim_was_valid (rsp_vv)
   );

   assign rsp_tdata = {{(RSP_DATA_W - SLOT_W - 1){1'b0}}, rsp_vv, rsp_slot};

endmodule

/* sv/sbc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbc_checker
// Port-level checks for the sector buffer cache replacement core.
// ----------------------------------------------------------------------------
module sbc_checker
   import sbc_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tuser
);

   logic       req_beat;
   logic       rsp_beat;
   logic [1:0] open_ff;

   assign req_beat = req_tvalid && req_tready;
   assign rsp_beat = rsp_tvalid && rsp_tready;

   // requests accepted but not yet answered
   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= '0;
      end else if (req_beat && !rsp_beat) begin
         open_ff <= open_ff + 1'b1;
      end else if (rsp_beat && !req_beat) begin
         open_ff <= open_ff - 1'b1;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                    && $stable(rsp_tuser))
      else $error("response beat changed while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> !req_tready)
      else $error("request accepted while one is in progress");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (open_ff != 2'd0) && (open_ff != 2'd3))
      else $error("response without an open request");

   a_hit_no_victim: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> !rsp_tdata[SLOT_W])
      else $error("hit reported with a replaced victim");

endmodule

bind sector_buffer_cache_replacement_core sbc_checker u_sbc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
